/* rtl/srvr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srvr_pkg
// Shared constants, types and field packing for the status report relay.
// ----------------------------------------------------------------------------
package srvr_pkg;

    localparam int REPORT_BYTES = 32;
    localparam int POS_W        = 6;
    localparam logic [POS_W-1:0] POS_MAX  = '1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(REPORT_BYTES);

    localparam logic [POS_W-1:0] POS_TYPE   = 6'd0;
    localparam logic [POS_W-1:0] POS_SES    = 6'd1;
    localparam logic [POS_W-1:0] POS_WK     = 6'd2;
    localparam logic [POS_W-1:0] POS_RST_LO = 6'd3;
    localparam logic [POS_W-1:0] POS_RST_HI = 6'd4;
    localparam logic [POS_W-1:0] POS_FLG    = 6'd5;
    localparam logic [POS_W-1:0] POS_ERR    = 6'd6;
    localparam logic [POS_W-1:0] POS_XP     = 6'd7;
    localparam logic [POS_W-1:0] POS_XA_LO  = 6'd8;
    localparam logic [POS_W-1:0] POS_XA_HI  = 6'd9;

    localparam logic [7:0] TYPE_BYTE     = 8'hB2;
    localparam logic [7:0] PCT_MAX       = 8'd100;
    localparam logic [7:0] FLAGS_ALLOWED = 8'd7;
    localparam logic [7:0] ERROR_MAX     = 8'd3;
    localparam logic [1:0] ERROR_NONE    = 2'd0;
    localparam int FLAG_STALE_BIT  = 0;
    localparam int FLAG_SAMPLE_BIT = 1;
    localparam int FLAG_EXTRA_BIT  = 2;

    localparam int RST_W  = 16;
    localparam int AGE_W  = 27;
    localparam int HB_W   = 22;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 2'd2;

    localparam logic [RST_W-1:0] MAX_RESET_DEFAULT = 16'd10080;
    localparam logic [AGE_W-1:0] STALE_DEFAULT     = 27'd60000;
    localparam logic [HB_W-1:0]  HEARTBEAT_DEFAULT = 22'd5000;

    localparam logic CAUSE_NEW       = 1'b0;
    localparam logic CAUSE_HEARTBEAT = 1'b1;

    typedef struct packed {
        logic [15:0] xa;
        logic [6:0]  xp;
        logic [1:0]  err;
        logic [2:0]  flg;
        logic [15:0] rst;
        logic [6:0]  wk;
        logic [6:0]  ses;
    } fields_t;

    typedef struct packed {
        logic    is_tick;
        fields_t fields;
    } cmd_t;

    typedef struct packed {
        logic [RST_W-1:0] max_reset;
        logic [AGE_W-1:0] stale_timeout;
        logic [HB_W-1:0]  hb_period;
    } cfg_t;

    function automatic logic cross_ok(fields_t f, logic [RST_W-1:0] max_reset);
        logic sample;
        logic extra;
        logic ok;
        sample = f.flg[FLAG_SAMPLE_BIT];
        extra  = f.flg[FLAG_EXTRA_BIT];
        ok     = 1'b1;
        if (f.rst > max_reset)
            ok = 1'b0;
        if (!sample && ((f.ses != '0) || (f.wk != '0) || (f.rst != '0) ||
                        (f.xp != '0) || (f.xa != '0) || extra || (f.err == ERROR_NONE)))
            ok = 1'b0;
        if (!extra && ((f.xp != '0) || (f.xa != '0)))
            ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [31:0] pack_a(fields_t f);
        return {f.rst, 1'b0, f.wk, 1'b0, f.ses};
    endfunction

    function automatic logic [27:0] pack_b(fields_t f, logic stale);
        logic [2:0] flags;
        flags = f.flg;
        flags[FLAG_STALE_BIT] = flags[FLAG_STALE_BIT] | stale;
        return {f.xa, f.xp, f.err, flags};
    endfunction

endpackage

`default_nettype wire

/* rtl/srvr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srvr_if
// Valid/ready channels of the status report relay: report input, relay
// output and configuration write.
// ----------------------------------------------------------------------------
interface srvr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, func, data_byte, last_byte, input ready);
    modport sink   (input valid, func, data_byte, last_byte, output ready);
endinterface

interface srvr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] relay_word_a;
    logic [27:0] relay_word_b;
    logic        relay_cause;

    modport source (output valid, relay_word_a, relay_word_b, relay_cause, input ready);
    modport sink   (input valid, relay_word_a, relay_word_b, relay_cause, output ready);
endinterface

interface srvr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [srvr_pkg::CFG_IDX_W-1:0]  idx;
    logic [srvr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

/* rtl/srvr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srvr_front
// Accepts report bytes and ticks, checks each frame as it arrives and
// forwards ticks and valid reports to the command queue.
// ----------------------------------------------------------------------------
module srvr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    srvr_in_if.sink             report,
    input  wire srvr_pkg::cfg_t cfg_regs,
    output srvr_pkg::cmd_t      push_cmd,
    output logic                push,
    input  wire logic           push_ready
);
    import srvr_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             bad_reg;
    logic             bad_next;
    fields_t          fields_reg;
    fields_t          fields_next;
    fields_t          fields_upd;
    logic             byte_bad;
    logic             accept;
    logic             frame_ok;
    logic [7:0]       b;

    assign report.ready = push_ready;
    assign accept       = report.valid && report.ready;
    assign b            = report.data_byte;

    always_comb
    begin
        byte_bad   = 1'b0;
        fields_upd = fields_reg;
        if (pos_reg >= POS_END)
        begin
            byte_bad = 1'b1;
        end
        else
        begin
            case (pos_reg)
                POS_TYPE:   byte_bad = (b != TYPE_BYTE);
                POS_SES:
                begin
                    byte_bad = (b > PCT_MAX);
                    if (!byte_bad)
                        fields_upd.ses = b[6:0];
                end
                POS_WK:
                begin
                    byte_bad = (b > PCT_MAX);
                    if (!byte_bad)
                        fields_upd.wk = b[6:0];
                end
                POS_RST_LO: fields_upd.rst[7:0]  = b;
                POS_RST_HI: fields_upd.rst[15:8] = b;
                POS_FLG:
                begin
                    byte_bad = ((b & ~FLAGS_ALLOWED) != '0);
                    if (!byte_bad)
                        fields_upd.flg = b[2:0];
                end
                POS_ERR:
                begin
                    byte_bad = (b > ERROR_MAX);
                    if (!byte_bad)
                        fields_upd.err = b[1:0];
                end
                POS_XP:
                begin
                    byte_bad = (b > PCT_MAX);
                    if (!byte_bad)
                        fields_upd.xp = b[6:0];
                end
                POS_XA_LO:  fields_upd.xa[7:0]  = b;
                POS_XA_HI:  fields_upd.xa[15:8] = b;
                default:    byte_bad = (b != '0);
            endcase
        end
    end

    assign frame_ok = !bad_reg && !byte_bad && (pos_reg == POS_LAST) &&
                      cross_ok(fields_upd, cfg_regs.max_reset);

    always_comb
    begin
        pos_next        = pos_reg;
        bad_next        = bad_reg;
        fields_next     = fields_reg;
        push            = 1'b0;
        push_cmd.is_tick = report.func;
        push_cmd.fields  = fields_upd;
        if (accept)
        begin
            if (report.func)
            begin
                push = 1'b1;
            end
            else if (report.last_byte)
            begin
                push        = frame_ok;
                pos_next    = '0;
                bad_next    = 1'b0;
                fields_next = '0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POS_W'(1);
                bad_next    = bad_reg | byte_bad;
                fields_next = fields_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            bad_reg    <= 1'b0;
            fields_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            bad_reg    <= bad_next;
            fields_reg <= fields_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/srvr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srvr_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module srvr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire srvr_pkg::cmd_t push_cmd,
    output logic                push_ready,
    output logic                head_valid,
    output srvr_pkg::cmd_t      head_cmd,
    input  wire logic           pop
);
    import srvr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

/* rtl/srvr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srvr_back
// Holds the latched report, ages it, runs the heartbeat and drives the
// relay output register.
// ----------------------------------------------------------------------------
module srvr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire srvr_pkg::cfg_t cfg_regs,
    input  wire logic           head_valid,
    input  wire srvr_pkg::cmd_t head_cmd,
    output logic                pop,
    srvr_out_if.source          relay
);
    import srvr_pkg::*;

    fields_t          held_reg;
    logic             held_valid_reg;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_inc;
    logic [AGE_W-1:0] age_used;
    logic [HB_W-1:0]  hb_reg;
    logic [HB_W-1:0]  hb_inc;
    logic             fire;
    logic             emits;
    logic             stale;
    logic             cause;
    fields_t          src;
    logic             out_free;
    logic             out_valid_reg;
    logic [31:0]      word_a_reg;
    logic [27:0]      word_b_reg;
    logic             cause_reg;

    assign out_free = !out_valid_reg || relay.ready;

    always_comb
    begin
        age_inc = (age_reg < AGE_MAX) ? age_reg + AGE_W'(1) : age_reg;
        hb_inc  = hb_reg + HB_W'(1);
        fire    = (hb_inc >= cfg_regs.hb_period);
        if (head_cmd.is_tick)
        begin
            emits    = fire && held_valid_reg;
            src      = held_reg;
            age_used = age_inc;
            cause    = CAUSE_HEARTBEAT;
        end
        else
        begin
            emits    = 1'b1;
            src      = head_cmd.fields;
            age_used = '0;
            cause    = CAUSE_NEW;
        end
        stale = (age_used >= cfg_regs.stale_timeout);
        pop   = head_valid && (!emits || out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            age_reg        <= '0;
            hb_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head_cmd.is_tick)
                begin
                    age_reg <= age_inc;
                    hb_reg  <= fire ? '0 : hb_inc;
                end
                else
                begin
                    held_reg       <= head_cmd.fields;
                    held_valid_reg <= 1'b1;
                    age_reg        <= '0;
                end
            end
            if (pop && emits)
                out_valid_reg <= 1'b1;
            else if (relay.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emits)
        begin
            word_a_reg <= pack_a(src);
            word_b_reg <= pack_b(src, stale);
            cause_reg  <= cause;
        end
    end

    assign relay.valid        = out_valid_reg;
    assign relay.relay_word_a = word_a_reg;
    assign relay.relay_word_b = word_b_reg;
    assign relay.relay_cause  = cause_reg;

endmodule

`default_nettype wire

/* rtl/status_report_validate_relay.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// status_report_validate_relay
// Validates byte-serial status reports and relays the latched report on
// acceptance and on every heartbeat period once a report is held.
// ----------------------------------------------------------------------------
// A request passes the command queue and then, if it emits, the relay output
// register before relay valid rises; a stalled relay holds the back part.
// Throughput: one request (report byte or tick) per cycle while the queue has
// room, set by the per-byte frame check in front and one command per cycle back.
// Reset: frame state, held report, age and heartbeat count clear; the three
// registers return to 10080, 60000 and 5000; no relay is pending.
module status_report_validate_relay (
    input  wire logic  clk,
    input  wire logic  rst_n,
    srvr_in_if.sink    report,
    srvr_out_if.source relay,
    srvr_cfg_if.sink   cfg
);
    import srvr_pkg::*;

    cfg_t cfg_reg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic push_ready;
    logic head_valid;
    logic pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_reset     <= MAX_RESET_DEFAULT;
            cfg_reg.stale_timeout <= STALE_DEFAULT;
            cfg_reg.hb_period     <= HEARTBEAT_DEFAULT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.idx)
                CFG_MAX_RESET: cfg_reg.max_reset     <= cfg.data[RST_W-1:0];
                CFG_STALE:     cfg_reg.stale_timeout <= cfg.data[AGE_W-1:0];
                CFG_HEARTBEAT: cfg_reg.hb_period     <= cfg.data[HB_W-1:0];
                default:       ;
            endcase
        end
    end

    srvr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .report     (report),
        .cfg_regs   (cfg_reg),
        .push_cmd   (push_cmd),
        .push       (push),
        .push_ready (push_ready)
    );

    srvr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    srvr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .relay      (relay)
    );

endmodule

`default_nettype wire

/* rtl/srvr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srvr_checker
// Port-level checks of the relay channel, bound to the top level.
// ----------------------------------------------------------------------------
module srvr_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        relay_valid,
    input  wire logic        relay_ready,
    input  wire logic [31:0] relay_word_a,
    input  wire logic [27:0] relay_word_b,
    input  wire logic        relay_cause
);
    import srvr_pkg::*;

    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (relay_valid && relay_ready && (relay_cause == CAUSE_NEW))
            seen_reg <= 1'b1;
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        relay_valid && !relay_ready |=> relay_valid)
        else $error("relay valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        relay_valid && !relay_ready |=>
            $stable(relay_word_a) && $stable(relay_word_b) && $stable(relay_cause))
        else $error("relay payload changed while stalled");

    a_heartbeat_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
        relay_valid && (relay_cause == CAUSE_HEARTBEAT) |-> seen_reg)
        else $error("heartbeat relay before any report was relayed");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        relay_valid |-> (relay_word_a[7:0] <= PCT_MAX) && (relay_word_a[15:8] <= PCT_MAX)
                        && (relay_word_b[11:5] <= PCT_MAX[6:0]))
        else $error("relayed percentage out of range");

endmodule

bind status_report_validate_relay srvr_checker u_srvr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .relay_valid  (relay.valid),
    .relay_ready  (relay.ready),
    .relay_word_a (relay.relay_word_a),
    .relay_word_b (relay.relay_word_b),
    .relay_cause  (relay.relay_cause)
);

`default_nettype wire
